FILE: rtl/bfrm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the byte fifo with rewind mark
// no dependencies

package bfrm_pkg;

   localparam int unsigned DEPTH_DEF  = 256;
   localparam int unsigned CAP_RESET  = 256;
   localparam int unsigned CAP_W      = 9;
   localparam int unsigned OP_W       = 3;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned FILL_W     = 9;
   localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] IDLE_BYTE  = 8'h00;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_MARK   = 3'd2,
      OP_UNMARK = 3'd3,
      OP_REWIND = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [BYTE_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic              done_res;
      logic [BYTE_W-1:0] data_out;
      logic [FILL_W-1:0] fill_count;
      logic              is_empty;
      logic              is_full;
   } rsp_type;

endpackage

FILE: rtl/bfrm_rewind.sv
`timescale 1ns / 1ps
// closed-form rewind: read pointer moves back by min(distance to mark, free space)
// depends on nothing but its DEPTH parameter

module bfrm_rewind #(
   parameter int unsigned DEPTH = 256
) (
   input  logic [$clog2(DEPTH)-1:0]   rd_ptr,
   input  logic [$clog2(DEPTH)-1:0]   mark_ptr,
   input  logic [$clog2(DEPTH+1)-1:0] held,
   input  logic [$clog2(DEPTH+1)-1:0] cap,
   output logic [$clog2(DEPTH)-1:0]   new_rd_ptr,
   output logic [$clog2(DEPTH+1)-1:0] new_held
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH+1);
   localparam int unsigned EXT_W = CNT_W + 1;

   logic [EXT_W-1:0] rd_e;
   logic [EXT_W-1:0] mk_e;
   logic [EXT_W-1:0] cap_e;
   logic [EXT_W-1:0] steps_e;
   logic [EXT_W-1:0] dist_e;
   logic [EXT_W-1:0] back_e;
   logic [CNT_W-1:0] span;
   logic [CNT_W-1:0] room;
   logic [CNT_W-1:0] steps;

   always_comb begin
      rd_e  = EXT_W'(rd_ptr);
      mk_e  = EXT_W'(mark_ptr);
      cap_e = EXT_W'(cap);
      // both pointers are below cap, so one wrap correction is enough
      dist_e = (rd_e >= mk_e) ? (rd_e - mk_e) : (rd_e + cap_e - mk_e);
      span   = CNT_W'(dist_e);
      room   = cap - held;
      steps  = (span < room) ? span : room;
      steps_e = EXT_W'(steps);
      back_e = (rd_e >= steps_e) ? (rd_e - steps_e) : (rd_e + cap_e - steps_e);
      new_rd_ptr = PTR_W'(back_e);
      new_held   = held + steps;
   end

endmodule

FILE: rtl/byte_fifo_with_rewind_mark.sv
`timescale 1ns / 1ps
// top level of the circular byte fifo with read pointer rewind
// depends on bfrm_pkg and bfrm_rewind

// One transaction is taken per clock whenever the result register is free or being
// drained; its result appears the cycle after acceptance, with popped data supplied
// by the registered read port of the byte store. req_stall rises only while a result
// waits under rsp_stall. A write on the csr port sets the capacity (0 reads as 1,
// values above DEPTH as DEPTH), empties the fifo and drops the mark. No clearing
// pass runs after reset: bytes are only read after they were pushed.

module byte_fifo_with_rewind_mark #(
   parameter int unsigned DEPTH = bfrm_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bfrm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bfrm_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [bfrm_pkg::CAP_W-1:0]    csr_wr_data
);

   localparam int unsigned PTR_W    = $clog2(DEPTH);
   localparam int unsigned CNT_W    = $clog2(DEPTH+1);
   localparam int unsigned CAP_INIT =
      (bfrm_pkg::CAP_RESET > DEPTH) ? DEPTH : bfrm_pkg::CAP_RESET;

   logic [bfrm_pkg::BYTE_W-1:0] store_mem [DEPTH];

   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [PTR_W-1:0] mark_ff, mark_in;
   logic             mark_act_ff, mark_act_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bfrm_pkg::rsp_type rsp_ff, rsp_in;
   logic             from_mem_ff;
   logic [bfrm_pkg::BYTE_W-1:0] rd_byte_ff;

   logic             accept;
   logic             mem_wr;
   logic             mem_rd;
   logic             done;
   logic [bfrm_pkg::BYTE_W-1:0] dout;
   logic [CNT_W-1:0] cap_cfg;
   logic [CNT_W-1:0] wr_inc;
   logic [CNT_W-1:0] rd_inc;
   logic [PTR_W-1:0] wr_next;
   logic [PTR_W-1:0] rd_next;
   logic [PTR_W-1:0] rw_rd_ptr;
   logic [CNT_W-1:0] rw_held;

   bfrm_rewind #(
      .DEPTH (DEPTH)
   ) u_rewind (
      .rd_ptr     (rd_ptr_ff),
      .mark_ptr   (mark_ff),
      .held       (held_ff),
      .cap        (cap_ff),
      .new_rd_ptr (rw_rd_ptr),
      .new_held   (rw_held)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (csr_wr_data == '0) begin
         cap_cfg = CNT_W'(1);
      end else if (32'(csr_wr_data) > 32'(DEPTH)) begin
         cap_cfg = CNT_W'(DEPTH);
      end else begin
         cap_cfg = CNT_W'(csr_wr_data);
      end
   end

   // pointer increments wrap at the programmed capacity
   always_comb begin
      wr_inc  = CNT_W'(wr_ptr_ff) + CNT_W'(1);
      rd_inc  = CNT_W'(rd_ptr_ff) + CNT_W'(1);
      wr_next = (wr_inc == cap_ff) ? '0 : PTR_W'(wr_inc);
      rd_next = (rd_inc == cap_ff) ? '0 : PTR_W'(rd_inc);
   end

   always_comb begin
      cap_in      = cap_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      held_in     = held_ff;
      mark_in     = mark_ff;
      mark_act_in = mark_act_ff;
      mem_wr      = 1'b0;
      mem_rd      = 1'b0;
      done        = 1'b1;
      dout        = bfrm_pkg::IDLE_BYTE;

      if (accept) begin
         unique case (bfrm_pkg::op_type'(req_data.operation))
            bfrm_pkg::OP_PUSH: begin
               if (held_ff != cap_ff) begin
                  wr_ptr_in = wr_next;
                  held_in   = held_ff + CNT_W'(1);
                  mem_wr    = 1'b1;
               end else begin
                  done = 1'b0;
               end
            end
            bfrm_pkg::OP_POP: begin
               if (held_ff != '0) begin
                  rd_ptr_in = rd_next;
                  held_in   = held_ff - CNT_W'(1);
                  mem_rd    = 1'b1;
               end else begin
                  done = 1'b0;
                  dout = bfrm_pkg::EMPTY_BYTE;
               end
            end
            bfrm_pkg::OP_MARK: begin
               mark_in     = rd_ptr_ff;
               mark_act_in = 1'b1;
            end
            bfrm_pkg::OP_UNMARK: begin
               mark_act_in = 1'b0;
            end
            bfrm_pkg::OP_REWIND: begin
               if (mark_act_ff) begin
                  rd_ptr_in = rw_rd_ptr;
                  held_in   = rw_held;
               end
            end
            bfrm_pkg::OP_CLEAR: begin
               rd_ptr_in   = '0;
               wr_ptr_in   = '0;
               held_in     = '0;
               mark_act_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (csr_wr_en) begin
         cap_in      = cap_cfg;
         rd_ptr_in   = '0;
         wr_ptr_in   = '0;
         held_in     = '0;
         mark_act_in = 1'b0;
      end

      rsp_valid_in        = accept || req_stall;
      rsp_in.done_res     = done;
      rsp_in.data_out     = dout;
      rsp_in.fill_count   = bfrm_pkg::FILL_W'(held_in);
      rsp_in.is_empty     = (held_in == '0);
      rsp_in.is_full      = (held_in == cap_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CNT_W'(CAP_INIT);
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         held_ff      <= '0;
         mark_ff      <= '0;
         mark_act_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         held_ff      <= held_in;
         mark_ff      <= mark_in;
         mark_act_ff  <= mark_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload only moves when a new transaction is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff      <= rsp_in;
         from_mem_ff <= mem_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         store_mem[wr_ptr_ff] <= req_data.data_in;
      end
      if (mem_rd) begin
         rd_byte_ff <= store_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      rsp_data = rsp_ff;
      if (from_mem_ff) begin
         rsp_data.data_out = rd_byte_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/bfrm_checker.sv
`timescale 1ns / 1ps
// port-level checks for byte_fifo_with_rewind_mark, bound to the top level
// depends on bfrm_pkg

module bfrm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input bfrm_pkg::req_type          req_data,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input bfrm_pkg::rsp_type          rsp_data
);

   // capacity is at least one, so a result is never both empty and full
   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.fill_count == '0))
                    && !(rsp_data.is_empty && rsp_data.is_full))
      else $error("empty/full flags disagree with fill count");

   // a failed pop only happens on an empty fifo
   a_failed_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.done_res && rsp_data.data_out == bfrm_pkg::EMPTY_BYTE)
         |-> rsp_data.is_empty)
      else $error("pop refused while fifo held data");

   // a refused push only happens on a full fifo
   a_refused_push_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.done_res && rsp_data.data_out == bfrm_pkg::IDLE_BYTE)
         |-> rsp_data.is_full)
      else $error("push refused while fifo had room");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result transaction changed");

   // mark, unmark, rewind, clear and spare codes always succeed with an idle byte
   a_control_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.operation >= bfrm_pkg::OP_MARK)
         |=> (rsp_valid && rsp_data.done_res
              && rsp_data.data_out == bfrm_pkg::IDLE_BYTE))
      else $error("control transaction gave a wrong result");

endmodule

bind byte_fifo_with_rewind_mark bfrm_checker u_bfrm_checker (.*);

FILE: tb/byte_fifo_with_rewind_mark_tb.sv
`timescale 1ns / 1ps
// testbench for byte_fifo_with_rewind_mark: directed and random operations checked
// against a cycle-free fifo predictor; depends on bfrm_pkg and the rtl top level

module byte_fifo_with_rewind_mark_tb;

   localparam logic [bfrm_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [bfrm_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;
   localparam int unsigned LIMIT_CYCLES = 200000;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_PATTERN,
      STALL_LIGHT,
      STALL_HEAVY
   } stall_mode_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bfrm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bfrm_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [bfrm_pkg::CAP_W-1:0] csr_wr_data = '0;

   // predicted fifo state
   logic [bfrm_pkg::BYTE_W-1:0] fifo_bytes [bfrm_pkg::DEPTH_DEF];
   int unsigned read_ptr;
   int unsigned write_ptr;
   int unsigned held_bytes;
   int unsigned mark_ptr;
   bit mark_on;
   logic [bfrm_pkg::CAP_W-1:0] capacity_reg;

   bfrm_pkg::rsp_type expected_rsp [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sent_count = 0;
   int unsigned burst_left = 0;
   bit sender_steady = 1'b0;

   stall_mode_type stall_mode = STALL_NONE;
   int unsigned stall_phase = 0;
   logic [31:0] stall_mask = '0;

   byte_fifo_with_rewind_mark u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int unsigned capacity_in_use();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > bfrm_pkg::DEPTH_DEF) return bfrm_pkg::DEPTH_DEF;
      return 32'(capacity_reg);
   endfunction

   function automatic void empty_fifo();
      read_ptr = 0;
      write_ptr = 0;
      held_bytes = 0;
      mark_on = 1'b0;
   endfunction

   function automatic bfrm_pkg::rsp_type predict_fifo(bfrm_pkg::req_type item);
      bfrm_pkg::rsp_type res;
      int unsigned lim;
      int unsigned span;
      int unsigned room;
      int unsigned steps;
      lim = capacity_in_use();
      res = '0;
      res.done_res = 1'b1;
      res.data_out = bfrm_pkg::IDLE_BYTE;
      case (item.operation)
         bfrm_pkg::OP_PUSH: begin
            if (held_bytes < lim && write_ptr < lim) begin
               fifo_bytes[write_ptr] = item.data_in;
               write_ptr = (write_ptr + 1 >= lim) ? 0 : write_ptr + 1;
               held_bytes++;
            end else begin
               res.done_res = 1'b0;
            end
         end
         bfrm_pkg::OP_POP: begin
            if (held_bytes > 0 && read_ptr < lim) begin
               res.data_out = fifo_bytes[read_ptr];
               read_ptr = (read_ptr + 1 >= lim) ? 0 : read_ptr + 1;
               held_bytes--;
            end else begin
               res.data_out = bfrm_pkg::EMPTY_BYTE;
               res.done_res = 1'b0;
            end
         end
         bfrm_pkg::OP_MARK: begin
            mark_ptr = read_ptr;
            mark_on = 1'b1;
         end
         bfrm_pkg::OP_UNMARK: mark_on = 1'b0;
         bfrm_pkg::OP_REWIND: begin
            // back toward the mark, but never past the write side
            if (mark_on && held_bytes <= lim) begin
               span = ((read_ptr % lim) + lim - (mark_ptr % lim)) % lim;
               room = lim - held_bytes;
               steps = (span < room) ? span : room;
               read_ptr = ((read_ptr % lim) + lim - steps) % lim;
               held_bytes += steps;
            end
         end
         bfrm_pkg::OP_CLEAR: empty_fifo();
         default: ;
      endcase
      res.fill_count = held_bytes[bfrm_pkg::FILL_W-1:0];
      res.is_empty = (held_bytes == 0);
      res.is_full = (held_bytes >= lim);
      return res;
   endfunction

   function automatic void check_result(bfrm_pkg::rsp_type got);
      bfrm_pkg::rsp_type want;
      if (expected_rsp.size() == 0) begin
         $error("result %h arrived with nothing expected", got);
         mismatch_count++;
         return;
      end
      want = expected_rsp.pop_front();
      if (got.done_res !== want.done_res) begin
         $error("done_res expected %0d actual %0d", want.done_res, got.done_res);
         mismatch_count++;
      end
      if (got.data_out !== want.data_out) begin
         $error("data_out expected %0d actual %0d", want.data_out, got.data_out);
         mismatch_count++;
      end
      if (got.fill_count !== want.fill_count) begin
         $error("fill_count expected %0d actual %0d", want.fill_count, got.fill_count);
         mismatch_count++;
      end
      if (got.is_empty !== want.is_empty) begin
         $error("is_empty expected %0d actual %0d", want.is_empty, got.is_empty);
         mismatch_count++;
      end
      if (got.is_full !== want.is_full) begin
         $error("is_full expected %0d actual %0d", want.is_full, got.is_full);
         mismatch_count++;
      end
   endfunction

   // every transaction on both channels and the csr port, seen at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         empty_fifo();
         mark_ptr = 0;
         capacity_reg = bfrm_pkg::CAP_RESET;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result(rsp_data);
         if (csr_wr_en) begin
            capacity_reg = csr_wr_data;
            empty_fifo();
         end
         if (req_valid && req_stall === 1'b0) expected_rsp.push_back(predict_fifo(req_data));
      end
   end

   // receiver back-pressure, with mode and mask re-chosen whenever the phase counter runs out
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_phase <= $urandom_range(20, 80);
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_mask <= $urandom;
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_PATTERN: rsp_stall <= stall_mask[5'(stall_phase % 32)];
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_op(input logic [bfrm_pkg::OP_W-1:0] op,
                          input logic [bfrm_pkg::BYTE_W-1:0] value);
      bfrm_pkg::req_type item;
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (!sender_steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.operation = op;
      item.data_in = value;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      sent_count++;
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [bfrm_pkg::CAP_W-1:0] value);
      wait_all_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [bfrm_pkg::OP_W-1:0] pick_op(int unsigned push_pct);
      int unsigned roll;
      if ($urandom_range(0, 99) < push_pct) return bfrm_pkg::OP_PUSH;
      roll = $urandom_range(0, 99);
      if (roll < 50) return bfrm_pkg::OP_POP;
      if (roll < 63) return bfrm_pkg::OP_MARK;
      if (roll < 81) return bfrm_pkg::OP_REWIND;
      if (roll < 88) return bfrm_pkg::OP_UNMARK;
      if (roll < 92) return bfrm_pkg::OP_CLEAR;
      if (roll < 96) return OP_SPARE6;
      return OP_SPARE7;
   endfunction

   // fill a little, mark, read ahead, refill, then rewind once or twice
   task automatic send_rewind_episode();
      int unsigned fills;
      int unsigned pops;
      int unsigned refills;
      fills = $urandom_range(0, 5);
      pops = $urandom_range(0, 6);
      refills = $urandom_range(0, 4);
      repeat (fills) send_op(bfrm_pkg::OP_PUSH, 8'($urandom));
      send_op(bfrm_pkg::OP_MARK, 8'($urandom));
      repeat (pops) send_op(bfrm_pkg::OP_POP, 8'($urandom));
      repeat (refills) send_op(bfrm_pkg::OP_PUSH, 8'($urandom));
      send_op(bfrm_pkg::OP_REWIND, 8'($urandom));
      if ($urandom_range(0, 1) != 0) send_op(bfrm_pkg::OP_REWIND, 8'($urandom));
   endtask

   task automatic test_empty_fifo_ops();
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_REWIND, 8'hFF);
      send_op(OP_SPARE6, 8'h00);
      send_op(OP_SPARE7, 8'hFF);
      send_op(bfrm_pkg::OP_CLEAR, 8'h00);
   endtask

   task automatic test_mark_and_rewind();
      send_op(bfrm_pkg::OP_PUSH, 8'h00);
      send_op(bfrm_pkg::OP_PUSH, 8'hFF);
      send_op(bfrm_pkg::OP_PUSH, 8'h5A);
      send_op(bfrm_pkg::OP_MARK, 8'h00);
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_REWIND, 8'h00);
      // mark survives the rewind
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_REWIND, 8'h00);
      send_op(bfrm_pkg::OP_UNMARK, 8'h00);
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_REWIND, 8'h00);
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_CLEAR, 8'h00);
   endtask

   task automatic test_full_and_tiny_capacity();
      write_capacity(9'd2);
      send_op(bfrm_pkg::OP_PUSH, 8'h11);
      send_op(bfrm_pkg::OP_PUSH, 8'h22);
      send_op(bfrm_pkg::OP_PUSH, 8'h33);
      send_op(bfrm_pkg::OP_MARK, 8'h00);
      send_op(bfrm_pkg::OP_POP, 8'h00);
      send_op(bfrm_pkg::OP_PUSH, 8'h44);
      // full, so there is no room to rewind into
      send_op(bfrm_pkg::OP_REWIND, 8'h00);
      write_capacity(9'd0);
      send_op(bfrm_pkg::OP_PUSH, 8'hC3);
      send_op(bfrm_pkg::OP_PUSH, 8'h3C);
   endtask

   task automatic test_random_traffic(input logic [bfrm_pkg::CAP_W-1:0] cap_value,
                                      input int unsigned count,
                                      input int unsigned push_pct,
                                      input bit steady);
      int unsigned stop_at;
      write_capacity(cap_value);
      sender_steady = steady;
      stop_at = sent_count + count;
      while (sent_count < stop_at) begin
         if ($urandom_range(0, 4) == 0) send_rewind_episode();
         else send_op(pick_op(push_pct), 8'($urandom));
      end
      sender_steady = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_fifo_ops();
      test_mark_and_rewind();
      test_full_and_tiny_capacity();
      test_random_traffic(9'd4, 200, 40, 1'b0);
      test_random_traffic(9'd17, 200, 45, 1'b1);
      test_random_traffic(9'd511, 350, 85, 1'b0);
      test_random_traffic(9'd1, 80, 40, 1'b0);
      test_random_traffic(9'd0, 50, 40, 1'b1);
      test_random_traffic(9'd256, 150, 50, 1'b0);
      test_random_traffic(9'($urandom_range(2, 511)), 120, 45, 1'b0);
      test_random_traffic(9'd3, 100, 40, 1'b0);
      wait_all_results();
      repeat (2) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d results never arrived", expected_rsp.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
